FILE: hdl/aapc_pkg.sv
// Shared types and constants for the ARGB alpha pixel converter.
`default_nettype none

package aapc_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int LANES        = 3;

    localparam logic [CHANNEL_BITS-1:0] CH_MAX = '1;

    typedef enum logic [1:0] {
        MODE_PREMUL = 2'd0,
        MODE_DEMUL  = 2'd1,
        MODE_SWAP   = 2'd2,
        MODE_PASS   = 2'd3
    } conv_mode_t;

    typedef struct packed {
        logic [31:0] pixel_in;
        logic        last_pixel;
    } pix_req_t;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic        any_translucent;
        logic        last_out;
    } pix_rsp_t;

    // One colour channel of the long division: partial remainder, dividend bits
    // still to be brought down, quotient bits produced so far.
    typedef struct packed {
        logic [CHANNEL_BITS-1:0] part;
        logic [CHANNEL_BITS-1:0] rest;
        logic [CHANNEL_BITS-1:0] quo;
        logic                    sat;
    } lane_t;

    typedef struct packed {
        logic [31:0]             px;
        logic                    bypass;
        logic [CHANNEL_BITS-1:0] divisor;
        lane_t [LANES-1:0]       lane;
        logic                    translucent;
        logic                    last;
    } stage_t;

endpackage

`default_nettype wire

FILE: hdl/aapc_prep.sv
// Entry stage: channel products, divisor selection, bypass cases and the sticky flag.
`default_nettype none

module aapc_prep
    import aapc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire conv_mode_t mode,
    input  wire logic       up_valid,
    output logic            up_ready,
    input  wire pix_req_t   req,
    output logic            dn_valid,
    input  wire logic       dn_ready,
    output stage_t          dn_stage
);

    logic   valid_reg;
    logic   valid_next;
    logic   seen_reg;
    logic   seen_next;
    stage_t stage_reg;
    stage_t stage_next;
    logic   accept;

    logic [CHANNEL_BITS-1:0]   alpha;
    logic [CHANNEL_BITS-1:0]   mult;
    logic [CHANNEL_BITS-1:0]   chan [LANES];
    logic [2*CHANNEL_BITS-1:0] prod [LANES];
    logic                      seen_now;

    assign up_ready = !valid_reg || dn_ready;
    assign accept   = up_valid && up_ready;

    always_comb
    begin
        alpha   = req.pixel_in[31:24];
        chan[2] = req.pixel_in[23:16];
        chan[1] = req.pixel_in[15:8];
        chan[0] = req.pixel_in[7:0];

        seen_now  = seen_reg || (alpha != CH_MAX);
        seen_next = seen_reg;
        if (accept)
        begin
            seen_next = req.last_pixel ? 1'b0 : seen_now;
        end

        // Premultiply divides c*alpha by 255, demultiply divides c*255 by alpha.
        mult = (mode == MODE_PREMUL) ? alpha : CH_MAX;

        stage_next             = stage_reg;
        stage_next.px          = req.pixel_in;
        stage_next.divisor     = (mode == MODE_PREMUL) ? CH_MAX : alpha;
        stage_next.translucent = seen_now;
        stage_next.last        = req.last_pixel;
        stage_next.bypass      = 1'b1;

        unique case (mode)
            MODE_PREMUL:
            begin
                if (alpha == '0)
                begin
                    stage_next.px = '0;
                end
                else if (alpha != CH_MAX)
                begin
                    stage_next.bypass = 1'b0;
                end
            end
            MODE_DEMUL:
            begin
                stage_next.bypass = (alpha == '0) || (alpha == CH_MAX);
            end
            MODE_SWAP:
            begin
                stage_next.px = {req.pixel_in[31:24], req.pixel_in[7:0],
                                 req.pixel_in[15:8], req.pixel_in[23:16]};
            end
            default:
            begin
                stage_next.px = req.pixel_in;
            end
        endcase

        for (int i = 0; i < LANES; i++)
        begin
            prod[i] = {{CHANNEL_BITS{1'b0}}, chan[i]} * {{CHANNEL_BITS{1'b0}}, mult};
            stage_next.lane[i].part = prod[i][2*CHANNEL_BITS-1:CHANNEL_BITS];
            stage_next.lane[i].rest = prod[i][CHANNEL_BITS-1:0];
            stage_next.lane[i].quo  = '0;
            // A channel at or above alpha would give a quotient of 255 or more.
            stage_next.lane[i].sat  = (mode == MODE_DEMUL) && (chan[i] >= alpha);
        end

        valid_next = accept ? 1'b1 : (dn_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            seen_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            seen_reg  <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_stage = stage_reg;

endmodule

`default_nettype wire

FILE: hdl/aapc_div_cell.sv
// One restoring-division cell: yields one quotient bit per channel per pass.
`default_nettype none

module aapc_div_cell
    import aapc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   up_valid,
    output logic        up_ready,
    input  wire stage_t up_stage,
    output logic        dn_valid,
    input  wire logic   dn_ready,
    output stage_t      dn_stage
);

    logic   valid_reg;
    logic   valid_next;
    stage_t stage_reg;
    stage_t stage_next;
    logic   accept;

    logic [CHANNEL_BITS:0] trial [LANES];
    logic                  fits  [LANES];
    logic [CHANNEL_BITS:0] diff  [LANES];

    assign up_ready = !valid_reg || dn_ready;
    assign accept   = up_valid && up_ready;

    always_comb
    begin
        stage_next = up_stage;
        for (int i = 0; i < LANES; i++)
        begin
            trial[i] = {up_stage.lane[i].part, up_stage.lane[i].rest[CHANNEL_BITS-1]};
            fits[i]  = trial[i] >= {1'b0, up_stage.divisor};
            diff[i]  = trial[i] - {1'b0, up_stage.divisor};
            stage_next.lane[i].part = fits[i] ? diff[i][CHANNEL_BITS-1:0]
                                              : trial[i][CHANNEL_BITS-1:0];
            stage_next.lane[i].rest = {up_stage.lane[i].rest[CHANNEL_BITS-2:0], 1'b0};
            stage_next.lane[i].quo  = {up_stage.lane[i].quo[CHANNEL_BITS-2:0], fits[i]};
        end
        valid_next = accept ? 1'b1 : (dn_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_stage = stage_reg;

endmodule

`default_nettype wire

FILE: hdl/argb_alpha_pixel_converter.sv
// Top level of the ARGB alpha premultiply / demultiply pixel converter.
//
//  Channel | Signals                     | Transfer
//  --------+-----------------------------+--------------------------------
//  input   | in_valid, in_ready, in_req  | request taken when valid & ready
//  output  | out_valid, out_ready, rsp   | result taken when valid & ready
//  config  | cfg_we, cfg_data            | mode written when cfg_we is high
//
// One pixel is accepted per cycle unless the output stalls the chain. It passes nine
// registers: the entry stage and a chain of 8 division cells, one quotient bit per cell.
// Reset clears the valid bits, the mode (premultiply) and the sticky flag.
// Every stage advances when it is empty or its successor advances, so bubbles
// close up and a stalled output holds the chain back one stage at a time.
`default_nettype none

module argb_alpha_pixel_converter
    import aapc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire pix_req_t   in_req,
    output logic            out_valid,
    input  wire logic       out_ready,
    output pix_rsp_t        out_rsp
);

    conv_mode_t mode_reg;
    conv_mode_t mode_next;

    stage_t stage_q [CHANNEL_BITS+1];
    logic   vld     [CHANNEL_BITS+1];
    logic   rdy     [CHANNEL_BITS+1];

    stage_t tail;
    logic [CHANNEL_BITS-1:0] res [LANES];

    always_comb
    begin
        mode_next = cfg_we ? conv_mode_t'(cfg_data) : mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PREMUL;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    aapc_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (mode_reg),
        .up_valid (in_valid),
        .up_ready (in_ready),
        .req      (in_req),
        .dn_valid (vld[0]),
        .dn_ready (rdy[0]),
        .dn_stage (stage_q[0])
    );

    for (genvar k = 0; k < CHANNEL_BITS; k++)
    begin : g_cell
        aapc_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (vld[k]),
            .up_ready (rdy[k]),
            .up_stage (stage_q[k]),
            .dn_valid (vld[k+1]),
            .dn_ready (rdy[k+1]),
            .dn_stage (stage_q[k+1])
        );
    end

    assign rdy[CHANNEL_BITS] = out_ready;
    assign tail              = stage_q[CHANNEL_BITS];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            res[i] = tail.lane[i].sat ? CH_MAX : tail.lane[i].quo;
        end
        out_rsp.pixel_out       = tail.bypass ? tail.px
                                              : {tail.px[31:24], res[2], res[1], res[0]};
        out_rsp.any_translucent = tail.translucent;
        out_rsp.last_out        = tail.last;
    end

    assign out_valid = vld[CHANNEL_BITS];

    // The entry can only refuse a pixel when every stage of the chain is occupied.
    a_full_when_blocked : assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (vld[0] && vld[1] && vld[2] && vld[3] && vld[4]
                       && vld[5] && vld[6] && vld[7] && vld[8]))
        else $error("input refused while the chain has a free stage");

    // After the last cell the remainder of every computed, unsaturated channel is below
    // the divisor; a saturated channel never used its quotient.
    a_remainder_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !tail.bypass) |->
            (tail.lane[0].sat || (tail.lane[0].part < tail.divisor))
            && (tail.lane[1].sat || (tail.lane[1].part < tail.divisor))
            && (tail.lane[2].sat || (tail.lane[2].part < tail.divisor)))
        else $error("division remainder not below divisor");

    // A result whose alpha is below full scale must report the image as translucent.
    a_translucent_flag : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_rsp.pixel_out[31:24] != CH_MAX)) |-> out_rsp.any_translucent)
        else $error("translucent pixel without sticky flag");

endmodule

`default_nettype wire
